[design/m1et_pkg.sv]
package m1et_pkg;

    localparam int DW         = 32;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 32;

    localparam logic [16:0] ONE16       = 17'd65536;
    localparam logic [16:0] F_BELOW_ONE = 17'd65535;
    localparam logic [30:0] ONE30       = 31'h4000_0000;
    localparam logic [31:0] LIGHT_RESET = 32'd65536;
    localparam logic [19:0] DEN_BASE    = 20'd327680;

    // Pipeline stage numbers; a value tagged with stage k sits in a register of stage k.
    localparam int ST_IN    = 1;
    localparam int ST_SQ    = 2;
    localparam int ST_SUM   = 3;
    localparam int ST_SC    = 4;
    localparam int ST_SCSQ  = 5;
    localparam int ST_S2    = 6;
    localparam int ST_MODF  = ST_SUM + SQRT_STEPS;
    localparam int ST_CMP   = ST_MODF + 1;
    localparam int ST_R     = ST_S2 + SQRT_STEPS;
    localparam int ST_Q     = ST_CMP + DIV_STEPS;
    localparam int ST_FQ    = ST_Q + 1;
    localparam int ST_F2    = ST_FQ + 1;
    localparam int ST_NQDIV = ST_R + DIV_STEPS;
    localparam int ST_NQ    = ST_NQDIV + 1;
    localparam int ST_NN    = ST_NQ + 1;
    localparam int ST_CN    = ST_F2 + 1;
    localparam int ST_SQI   = ST_CN + SQRT_STEPS;
    localparam int ST_DEN   = ST_SQI + 1;
    localparam int ST_CHIQ  = ST_DEN + DIV_STEPS;
    localparam int ST_AB    = ST_CHIQ + 1;
    localparam int ST_COEF  = ST_AB + 1;
    localparam int ST_PROD  = ST_COEF + 1;
    localparam int ST_OUT   = ST_PROD + 1;

    // Tensor terms in the order xx, yy, zz, xy, xz, yz, with their two axes.
    localparam int NUM_TERMS = 6;
    localparam int NUM_DIAG  = 3;
    localparam int PJ [NUM_TERMS] = '{0, 1, 2, 0, 0, 1};
    localparam int PK [NUM_TERMS] = '{0, 1, 2, 1, 2, 2};

    typedef logic [2:0][DW-1:0]            t_vec3;
    typedef logic [2:0][63:0]              t_sq3;
    typedef logic [2:0][30:0]              t_nq3;
    typedef logic [NUM_TERMS-1:0][30:0]    t_nn6;
    typedef logic [NUM_TERMS-1:0][47:0]    t_coef6;
    typedef logic [NUM_TERMS-1:0][31:0]    t_term6;

endpackage

[design/m1_eddington_tensor_top.sv]
// M1 closure pressure tensor. One cell beat can enter every clock cycle while o_stall is
// low. The deepest path is the chain of two 32-stage square-root units and two 32-stage
// dividers on the reduced-flux path (|F|, then f, then the root inside the Levermore
// factor, then chi). The whole pipeline advances together: it holds while a result
// waits on a stalled output, and o_stall is high exactly then. Write the light speed
// only while no beat is in flight.
module m1_eddington_tensor_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [31:0]        i_cfg_wr_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [31:0]        i_cell_tag,
    input  logic signed [31:0] i_flux_x,
    input  logic signed [31:0] i_flux_y,
    input  logic signed [31:0] i_flux_z,
    input  logic [31:0]        i_photon_density,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [31:0]        o_tag_out,
    output logic [31:0]        o_press_xx,
    output logic [31:0]        o_press_yy,
    output logic [31:0]        o_press_zz,
    output logic signed [31:0] o_press_xy,
    output logic signed [31:0] o_press_xz,
    output logic signed [31:0] o_press_yz,
    output logic signed [31:0] o_new_flux_x,
    output logic signed [31:0] o_new_flux_y,
    output logic signed [31:0] o_new_flux_z,
    output logic [16:0]        o_reduced_flux,
    output logic               o_was_clamped
);

    logic                             en;
    logic [31:0]                      r_light;
    logic [m1et_pkg::ST_IN:m1et_pkg::ST_OUT] r_vld;

    // Delay lines, indexed by stage.
    logic [31:0]     r_tag   [m1et_pkg::ST_IN:m1et_pkg::ST_OUT];
    logic [2:0]      r_neg   [m1et_pkg::ST_IN:m1et_pkg::ST_PROD];
    m1et_pkg::t_vec3 r_mag   [m1et_pkg::ST_IN:m1et_pkg::ST_FQ];
    logic [31:0]     r_e     [m1et_pkg::ST_IN:m1et_pkg::ST_COEF];
    logic [63:0]     r_d     [m1et_pkg::ST_SQ:m1et_pkg::ST_MODF];
    logic            r_nz    [m1et_pkg::ST_SUM:m1et_pkg::ST_NQDIV];
    m1et_pkg::t_vec3 r_sc    [m1et_pkg::ST_SC:m1et_pkg::ST_R];
    logic            r_clamp [m1et_pkg::ST_CMP:m1et_pkg::ST_OUT];
    logic            r_eq    [m1et_pkg::ST_CMP:m1et_pkg::ST_Q];
    logic            r_one   [m1et_pkg::ST_CMP:m1et_pkg::ST_Q];
    logic [16:0]     r_fq    [m1et_pkg::ST_FQ:m1et_pkg::ST_OUT];
    m1et_pkg::t_vec3 r_newf  [m1et_pkg::ST_F2:m1et_pkg::ST_PROD];
    logic [35:0]     r_cnum  [m1et_pkg::ST_CN:m1et_pkg::ST_DEN];
    m1et_pkg::t_nn6  r_nn    [m1et_pkg::ST_NN:m1et_pkg::ST_AB];

    // Single-stage registers.
    m1et_pkg::t_sq3   r_sq;
    logic [31:0]      r_maxa;
    logic [63:0]      r_mag2;
    logic [4:0]       r_sh;
    m1et_pkg::t_sq3   r_scsq;
    logic [63:0]      r_s2;
    logic [63:0]      r_dx;
    logic [63:0]      r_dy;
    logic [31:0]      r_sp;
    logic [33:0]      r_f2;
    logic [34:0]      r_inner;
    logic [19:0]      r_den;
    m1et_pkg::t_nq3   r_nq;
    logic [16:0]      r_a;
    logic [17:0]      r_b;
    m1et_pkg::t_coef6 r_coef;
    m1et_pkg::t_term6 r_p;
    m1et_pkg::t_term6 r_press;
    m1et_pkg::t_vec3  r_nf_out;

    // Next values.
    m1et_pkg::t_vec3  in_flux;
    logic [2:0]       n_neg;
    m1et_pkg::t_vec3  n_mag;
    m1et_pkg::t_sq3   n_sq;
    logic [63:0]      n_d;
    logic [31:0]      n_maxa;
    logic [63:0]      n_mag2;
    logic [4:0]       n_sh;
    logic             n_nz;
    m1et_pkg::t_vec3  n_sc;
    m1et_pkg::t_sq3   n_scsq;
    logic [63:0]      n_s2;
    logic             n_clamp;
    logic             n_eq;
    logic             n_one;
    logic [63:0]      n_dx;
    logic [63:0]      n_dy;
    logic [16:0]      n_fq;
    logic [31:0]      n_sp;
    logic [33:0]      n_f2;
    m1et_pkg::t_vec3  n_newf;
    logic [35:0]      n_cnum;
    logic [34:0]      n_inner;
    logic [19:0]      n_den;
    m1et_pkg::t_nq3   n_nq;
    m1et_pkg::t_nn6   n_nn;
    logic [16:0]      n_a;
    logic [17:0]      n_b;
    m1et_pkg::t_coef6 n_coef;
    m1et_pkg::t_term6 n_p;
    m1et_pkg::t_term6 n_press;
    m1et_pkg::t_vec3  n_nf_out;

    // Unit results.
    logic [31:0]     w_modf;
    logic [31:0]     w_root_n;
    logic [31:0]     w_sqi;
    logic [31:0]     w_fquot;
    logic [31:0]     w_chiq;
    logic [2:0][31:0] w_nquot;

    assign en      = !r_vld[m1et_pkg::ST_OUT] || !i_stall;
    assign o_stall = !en;
    assign o_valid = r_vld[m1et_pkg::ST_OUT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light <= m1et_pkg::LIGHT_RESET;
        end else if (i_cfg_wr_en) begin
            r_light <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {i_valid, r_vld[m1et_pkg::ST_IN:m1et_pkg::ST_OUT-1]};
        end
    end

    // Stage 1: sign and magnitude of each flux component.
    always_comb begin
        in_flux[0] = i_flux_x;
        in_flux[1] = i_flux_y;
        in_flux[2] = i_flux_z;
        for (int j = 0; j < 3; j++) begin
            n_neg[j] = in_flux[j][m1et_pkg::DW-1];
            n_mag[j] = n_neg[j] ? (~in_flux[j] + 32'd1) : in_flux[j];
        end
    end

    // Stage 2: squares, c*E (or c alone when E is zero) and the largest magnitude.
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_sq[j] = 64'(r_mag[m1et_pkg::ST_IN][j]) * 64'(r_mag[m1et_pkg::ST_IN][j]);
        end
        n_d = (r_e[m1et_pkg::ST_IN] == 32'd0) ? {32'd0, r_light}
            : 64'(r_light) * 64'(r_e[m1et_pkg::ST_IN]);
        n_maxa = r_mag[m1et_pkg::ST_IN][0];
        if (r_mag[m1et_pkg::ST_IN][1] > n_maxa) begin
            n_maxa = r_mag[m1et_pkg::ST_IN][1];
        end
        if (r_mag[m1et_pkg::ST_IN][2] > n_maxa) begin
            n_maxa = r_mag[m1et_pkg::ST_IN][2];
        end
    end

    // Stage 3: |F|^2, and the shift that brings the largest component to [2^30, 2^31].
    always_comb begin
        logic [31:0] cz_x;
        logic [4:0]  cz_n;
        n_mag2 = r_sq[0] + r_sq[1] + r_sq[2];
        cz_x = r_maxa;
        cz_n = 5'd0;
        if (cz_x[31:16] == 16'd0) begin
            cz_n = cz_n + 5'd16;
            cz_x = cz_x << 16;
        end
        if (cz_x[31:24] == 8'd0) begin
            cz_n = cz_n + 5'd8;
            cz_x = cz_x << 8;
        end
        if (cz_x[31:28] == 4'd0) begin
            cz_n = cz_n + 5'd4;
            cz_x = cz_x << 4;
        end
        if (cz_x[31:30] == 2'd0) begin
            cz_n = cz_n + 5'd2;
            cz_x = cz_x << 2;
        end
        if (!cz_x[31]) begin
            cz_n = cz_n + 5'd1;
        end
        n_sh = (cz_n == 5'd0) ? 5'd0 : cz_n - 5'd1;
        n_nz = (r_maxa != 32'd0);
    end

    // Stages 4 to 6: normalized flux and its squared length.
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_sc[j]   = r_mag[m1et_pkg::ST_SUM][j] << r_sh;
            n_scsq[j] = 64'(r_sc[m1et_pkg::ST_SC][j]) * 64'(r_sc[m1et_pkg::ST_SC][j]);
        end
        n_s2 = r_scsq[0] + r_scsq[1] + r_scsq[2];
    end

    m1et_sqrt u_sqrt_mod (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_x    (r_mag2),
        .o_root (w_modf)
    );

    m1et_sqrt u_sqrt_dir (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_x    (r_s2),
        .o_root (w_root_n)
    );

    // Compare |F|*2^16 with D and set up the one divider for either f or the clamp scale.
    always_comb begin
        logic [63:0] num;
        logic [63:0] dv;
        num     = {16'd0, w_modf, 16'd0};
        dv      = r_d[m1et_pkg::ST_MODF];
        n_clamp = (num > dv);
        n_eq    = (num == dv);
        n_one   = n_eq && (dv != 64'd0);
        if (n_clamp) begin
            n_dx = dv;
            n_dy = num;
        end else if (n_eq) begin
            n_dx = 64'd0;
            n_dy = 64'd1;
        end else begin
            n_dx = num;
            n_dy = dv;
        end
    end

    m1et_div u_div_f (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_x    (r_dx),
        .i_y    (r_dy),
        .o_quot (w_fquot)
    );

    always_comb begin
        if (r_clamp[m1et_pkg::ST_Q]) begin
            n_fq = m1et_pkg::F_BELOW_ONE;
        end else if (r_eq[m1et_pkg::ST_Q]) begin
            n_fq = r_one[m1et_pkg::ST_Q] ? m1et_pkg::ONE16 : 17'd0;
        end else begin
            n_fq = {1'b0, w_fquot[31:16]};
        end
        n_sp = w_fquot - (w_fquot >> 30);
    end

    // f^2 and the rescaled flux.
    always_comb begin
        logic [63:0] prod;
        n_f2 = 34'(r_fq[m1et_pkg::ST_FQ]) * 34'(r_fq[m1et_pkg::ST_FQ]);
        for (int j = 0; j < 3; j++) begin
            prod = 64'(r_mag[m1et_pkg::ST_FQ][j]) * 64'(r_sp);
            n_newf[j] = r_clamp[m1et_pkg::ST_FQ] ? prod[63:32] : r_mag[m1et_pkg::ST_FQ][j];
        end
    end

    always_comb begin
        n_cnum  = (36'd3 << 32) + {r_f2, 2'b00};
        n_inner = (35'd4 << 32) - 35'(36'(r_f2) * 36'd3);
        n_den   = m1et_pkg::DEN_BASE + {1'b0, w_sqi[17:0], 1'b0};
    end

    m1et_sqrt u_sqrt_chi (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_x    ({29'd0, r_inner}),
        .o_root (w_sqi)
    );

    m1et_div u_div_chi (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_x    ({28'd0, r_cnum[m1et_pkg::ST_DEN]}),
        .i_y    ({12'd0, r_den, 32'd0}),
        .o_quot (w_chiq)
    );

    for (genvar g = 0; g < 3; g++) begin : g_dir
        m1et_div u_div_n (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_x    ({32'd0, r_sc[m1et_pkg::ST_R][g]}),
            .i_y    ({30'd0, w_root_n, 2'b00}),
            .o_quot (w_nquot[g])
        );
    end

    // Unit direction, Q30, and its pairwise products.
    always_comb begin
        logic [61:0] pr;
        for (int j = 0; j < 3; j++) begin
            if (!r_nz[m1et_pkg::ST_NQDIV]) begin
                n_nq[j] = 31'd0;
            end else if (w_nquot[j] > 32'(m1et_pkg::ONE30)) begin
                n_nq[j] = m1et_pkg::ONE30;
            end else begin
                n_nq[j] = w_nquot[j][30:0];
            end
        end
        for (int t = 0; t < m1et_pkg::NUM_TERMS; t++) begin
            pr = 62'(r_nq[m1et_pkg::PJ[t]]) * 62'(r_nq[m1et_pkg::PK[t]]);
            n_nn[t] = pr[60:30];
        end
    end

    // Levermore factor and the two tensor weights.
    always_comb begin
        logic [16:0] chi;
        logic [18:0] chi3;
        chi  = (w_chiq > 32'(m1et_pkg::ONE16)) ? m1et_pkg::ONE16 : w_chiq[16:0];
        n_a  = m1et_pkg::ONE16 - chi;
        chi3 = 19'(chi) * 19'd3;
        n_b  = (chi3 > 19'(m1et_pkg::ONE16)) ? 18'(chi3 - 19'(m1et_pkg::ONE16)) : 18'd0;
    end

    always_comb begin
        logic [48:0] bn;
        logic [63:0] eh;
        for (int t = 0; t < m1et_pkg::NUM_TERMS; t++) begin
            bn = 49'(r_b) * 49'(r_nn[m1et_pkg::ST_AB][t]);
            if (t < m1et_pkg::NUM_DIAG) begin
                n_coef[t] = 48'({r_a, 30'd0}) + bn[47:0];
            end else begin
                n_coef[t] = bn[47:0];
            end
            eh = 64'(r_e[m1et_pkg::ST_COEF]) * 64'(r_coef[t][47:16]);
            n_p[t] = eh[62:31];
        end
    end

    // Signs of the off-diagonal terms and of the rescaled flux.
    always_comb begin
        logic sg;
        for (int t = 0; t < m1et_pkg::NUM_TERMS; t++) begin
            sg = (t >= m1et_pkg::NUM_DIAG)
                && (r_neg[m1et_pkg::ST_PROD][m1et_pkg::PJ[t]]
                    != r_neg[m1et_pkg::ST_PROD][m1et_pkg::PK[t]])
                && (r_p[t] != 32'd0);
            n_press[t] = sg ? (~r_p[t] + 32'd1) : r_p[t];
        end
        for (int j = 0; j < 3; j++) begin
            n_nf_out[j] = (r_neg[m1et_pkg::ST_PROD][j] && r_newf[m1et_pkg::ST_PROD][j] != 32'd0)
                ? (~r_newf[m1et_pkg::ST_PROD][j] + 32'd1) : r_newf[m1et_pkg::ST_PROD][j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tag[m1et_pkg::ST_IN] <= i_cell_tag;
            for (int k = m1et_pkg::ST_IN + 1; k <= m1et_pkg::ST_OUT; k++) begin
                r_tag[k] <= r_tag[k-1];
            end
            r_neg[m1et_pkg::ST_IN] <= n_neg;
            for (int k = m1et_pkg::ST_IN + 1; k <= m1et_pkg::ST_PROD; k++) begin
                r_neg[k] <= r_neg[k-1];
            end
            r_mag[m1et_pkg::ST_IN] <= n_mag;
            for (int k = m1et_pkg::ST_IN + 1; k <= m1et_pkg::ST_FQ; k++) begin
                r_mag[k] <= r_mag[k-1];
            end
            r_e[m1et_pkg::ST_IN] <= i_photon_density;
            for (int k = m1et_pkg::ST_IN + 1; k <= m1et_pkg::ST_COEF; k++) begin
                r_e[k] <= r_e[k-1];
            end
            r_d[m1et_pkg::ST_SQ] <= n_d;
            for (int k = m1et_pkg::ST_SQ + 1; k <= m1et_pkg::ST_MODF; k++) begin
                r_d[k] <= r_d[k-1];
            end
            r_nz[m1et_pkg::ST_SUM] <= n_nz;
            for (int k = m1et_pkg::ST_SUM + 1; k <= m1et_pkg::ST_NQDIV; k++) begin
                r_nz[k] <= r_nz[k-1];
            end
            r_sc[m1et_pkg::ST_SC] <= n_sc;
            for (int k = m1et_pkg::ST_SC + 1; k <= m1et_pkg::ST_R; k++) begin
                r_sc[k] <= r_sc[k-1];
            end
            r_clamp[m1et_pkg::ST_CMP] <= n_clamp;
            for (int k = m1et_pkg::ST_CMP + 1; k <= m1et_pkg::ST_OUT; k++) begin
                r_clamp[k] <= r_clamp[k-1];
            end
            r_eq[m1et_pkg::ST_CMP]  <= n_eq;
            r_one[m1et_pkg::ST_CMP] <= n_one;
            for (int k = m1et_pkg::ST_CMP + 1; k <= m1et_pkg::ST_Q; k++) begin
                r_eq[k]  <= r_eq[k-1];
                r_one[k] <= r_one[k-1];
            end
            r_fq[m1et_pkg::ST_FQ] <= n_fq;
            for (int k = m1et_pkg::ST_FQ + 1; k <= m1et_pkg::ST_OUT; k++) begin
                r_fq[k] <= r_fq[k-1];
            end
            r_newf[m1et_pkg::ST_F2] <= n_newf;
            for (int k = m1et_pkg::ST_F2 + 1; k <= m1et_pkg::ST_PROD; k++) begin
                r_newf[k] <= r_newf[k-1];
            end
            r_cnum[m1et_pkg::ST_CN] <= n_cnum;
            for (int k = m1et_pkg::ST_CN + 1; k <= m1et_pkg::ST_DEN; k++) begin
                r_cnum[k] <= r_cnum[k-1];
            end
            r_nn[m1et_pkg::ST_NN] <= n_nn;
            for (int k = m1et_pkg::ST_NN + 1; k <= m1et_pkg::ST_AB; k++) begin
                r_nn[k] <= r_nn[k-1];
            end

            r_sq     <= n_sq;
            r_maxa   <= n_maxa;
            r_mag2   <= n_mag2;
            r_sh     <= n_sh;
            r_scsq   <= n_scsq;
            r_s2     <= n_s2;
            r_dx     <= n_dx;
            r_dy     <= n_dy;
            r_sp     <= n_sp;
            r_f2     <= n_f2;
            r_inner  <= n_inner;
            r_den    <= n_den;
            r_nq     <= n_nq;
            r_a      <= n_a;
            r_b      <= n_b;
            r_coef   <= n_coef;
            r_p      <= n_p;
            r_press  <= n_press;
            r_nf_out <= n_nf_out;
        end
    end

    assign o_tag_out      = r_tag[m1et_pkg::ST_OUT];
    assign o_press_xx     = r_press[0];
    assign o_press_yy     = r_press[1];
    assign o_press_zz     = r_press[2];
    assign o_press_xy     = r_press[3];
    assign o_press_xz     = r_press[4];
    assign o_press_yz     = r_press[5];
    assign o_new_flux_x   = r_nf_out[0];
    assign o_new_flux_y   = r_nf_out[1];
    assign o_new_flux_z   = r_nf_out[2];
    assign o_reduced_flux = r_fq[m1et_pkg::ST_OUT];
    assign o_was_clamped  = r_clamp[m1et_pkg::ST_OUT];

endmodule

[design/m1et_sqrt.sv]
module m1et_sqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_x,
    output logic [31:0] o_root
);

    logic [63:0] r_x [0:m1et_pkg::SQRT_STEPS-1];
    logic [63:0] r_r [0:m1et_pkg::SQRT_STEPS-1];
    logic [63:0] n_x [0:m1et_pkg::SQRT_STEPS-1];
    logic [63:0] n_r [0:m1et_pkg::SQRT_STEPS-1];

    // One result bit per stage, most significant first.
    always_comb begin
        logic [63:0] xp;
        logic [63:0] rp;
        logic [63:0] bv;
        logic [63:0] trial;
        for (int i = 0; i < m1et_pkg::SQRT_STEPS; i++) begin
            xp    = (i == 0) ? i_x : r_x[(i == 0) ? 0 : i - 1];
            rp    = (i == 0) ? 64'd0 : r_r[(i == 0) ? 0 : i - 1];
            bv    = 64'd1 << (62 - 2 * i);
            trial = rp + bv;
            if (xp >= trial) begin
                n_x[i] = xp - trial;
                n_r[i] = (rp >> 1) + bv;
            end else begin
                n_x[i] = xp;
                n_r[i] = rp >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < m1et_pkg::SQRT_STEPS; i++) begin
                r_x[i] <= n_x[i];
                r_r[i] <= n_r[i];
            end
        end
    end

    assign o_root = r_r[m1et_pkg::SQRT_STEPS-1][31:0];

endmodule

[design/m1et_div.sv]
module m1et_div (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic [63:0]                      i_x,
    input  logic [63:0]                      i_y,
    output logic [m1et_pkg::DIV_STEPS-1:0]   o_quot
);

    // Fractional restoring division: o_quot = floor(x * 2^DIV_STEPS / y), x < y.
    logic [63:0]                    r_rem [0:m1et_pkg::DIV_STEPS-1];
    logic [63:0]                    r_y   [0:m1et_pkg::DIV_STEPS-1];
    logic [m1et_pkg::DIV_STEPS-1:0] r_q   [0:m1et_pkg::DIV_STEPS-1];
    logic [63:0]                    n_rem [0:m1et_pkg::DIV_STEPS-1];
    logic [63:0]                    n_y   [0:m1et_pkg::DIV_STEPS-1];
    logic [m1et_pkg::DIV_STEPS-1:0] n_q   [0:m1et_pkg::DIV_STEPS-1];

    always_comb begin
        logic [63:0]                    rp;
        logic [63:0]                    yp;
        logic [m1et_pkg::DIV_STEPS-1:0] qp;
        logic [64:0]                    t;
        logic [64:0]                    diff;
        for (int i = 0; i < m1et_pkg::DIV_STEPS; i++) begin
            rp   = (i == 0) ? i_x : r_rem[(i == 0) ? 0 : i - 1];
            yp   = (i == 0) ? i_y : r_y[(i == 0) ? 0 : i - 1];
            qp   = (i == 0) ? '0  : r_q[(i == 0) ? 0 : i - 1];
            t    = {rp, 1'b0};
            diff = t - {1'b0, yp};
            n_y[i] = yp;
            if (t >= {1'b0, yp}) begin
                n_rem[i] = diff[63:0];
                n_q[i]   = {qp[m1et_pkg::DIV_STEPS-2:0], 1'b1};
            end else begin
                n_rem[i] = t[63:0];
                n_q[i]   = {qp[m1et_pkg::DIV_STEPS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < m1et_pkg::DIV_STEPS; i++) begin
                r_rem[i] <= n_rem[i];
                r_y[i]   <= n_y[i];
                r_q[i]   <= n_q[i];
            end
        end
    end

    assign o_quot = r_q[m1et_pkg::DIV_STEPS-1];

endmodule

[tb/tb.sv]
module tb;

    typedef struct {
        logic [31:0] tag;
        logic [31:0] fx;
        logic [31:0] fy;
        logic [31:0] fz;
        logic [31:0] dens;
    } t_cell;

    typedef struct {
        logic [31:0] tag;
        logic [31:0] pxx, pyy, pzz, pxy, pxz, pyz;
        logic [31:0] nfx, nfy, nfz;
        logic [16:0] fq;
        logic        clamp;
    } t_tensor;

    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = m1et_pkg::ST_OUT + 20;
    localparam int DOG_LIMIT   = 6000;

    class t_tensor_board;
        bit [63:0] light;
        t_tensor   want_q[$];
        int        errors;

        function new();
            light  = 64'(m1et_pkg::LIGHT_RESET);
            errors = 0;
        endfunction

        function bit [63:0] root64(bit [63:0] x);
            bit [63:0] r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x) b >>= 2;
            while (b != 0) begin
                if (x >= r + b) begin
                    x -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function bit [31:0] with_sign(bit neg, bit [63:0] mag);
            return neg ? 32'(~mag + 64'd1) : 32'(mag);
        endfunction

        // Works out the tensor for one accepted cell beat.
        function void note_cell(t_cell c);
            bit [63:0] mag[3], nq[3], sc[3], newf[3], term[6];
            bit        neg[3], tneg[6];
            bit [63:0] e, d, mag2, modf, num, fq, maxa, rem, s, s2, r;
            bit [63:0] f2, cnum, inner, den, chi, a, b, nn, coef, h;
            bit [31:0] v;
            bit        clamp;
            int        sh, t;
            t_tensor   w;
            e = 64'(c.dens);
            mag2 = 0;
            maxa = 0;
            clamp = 0;
            sh = 0;
            for (int j = 0; j < 3; j++) begin
                v = (j == 0) ? c.fx : (j == 1) ? c.fy : c.fz;
                neg[j] = v[31];
                mag[j] = neg[j] ? 64'(32'(-v)) : 64'(v);
                if (neg[j] && mag[j] == 0) mag[j] = 64'd1 << 31;
                mag2 += mag[j] * mag[j];
                if (mag[j] > maxa) maxa = mag[j];
            end
            modf = root64(mag2);
            d = (e == 0) ? light : light * e;
            num = modf << 16;
            if (num > d) begin
                clamp = 1;
                fq = 65535;
                rem = d;
                s = 0;
                for (int j = 0; j < 32; j++) begin
                    rem <<= 1;
                    s <<= 1;
                    if (rem >= num) begin
                        rem -= num;
                        s |= 1;
                    end
                end
                s -= (s >> 30);
                for (int j = 0; j < 3; j++) newf[j] = (mag[j] * s) >> 32;
            end else begin
                if (num == d) begin
                    fq = (d == 0) ? 0 : 65536;
                end else begin
                    rem = num;
                    fq = 0;
                    for (int j = 0; j < 16; j++) begin
                        fq <<= 1;
                        if (rem >= d - rem) begin
                            rem = rem - (d - rem);
                            fq |= 1;
                        end else begin
                            rem <<= 1;
                        end
                    end
                end
                for (int j = 0; j < 3; j++) newf[j] = mag[j];
            end

            // Levermore factor in Q16.
            f2 = fq * fq;
            cnum = (64'd3 << 32) + 4 * f2;
            inner = (64'd4 << 32) - 3 * f2;
            den = 5 * 65536 + 2 * root64(inner);
            chi = cnum / den;
            if (chi > 65536) chi = 65536;
            a = 65536 - chi;
            b = (3 * chi > 65536) ? 3 * chi - 65536 : 0;

            // Direction in Q30, from a flux normalized so its largest part is near 2^30.
            if (maxa == 0) begin
                nq[0] = 0; nq[1] = 0; nq[2] = 0;
            end else begin
                while (maxa < (64'd1 << 30) && sh < 62) begin
                    maxa <<= 1;
                    sh++;
                end
                s2 = 0;
                for (int j = 0; j < 3; j++) begin
                    sc[j] = mag[j] << sh;
                    s2 += sc[j] * sc[j];
                end
                r = root64(s2);
                for (int j = 0; j < 3; j++) begin
                    nq[j] = (r == 0) ? 0 : (sc[j] << 30) / r;
                    if (nq[j] > (64'd1 << 30)) nq[j] = 64'd1 << 30;
                end
            end

            t = 3;
            for (int j = 0; j < 3; j++) begin
                for (int k = j; k < 3; k++) begin
                    nn = (nq[j] * nq[k]) >> 30;
                    coef = (j == k) ? a * (64'd1 << 30) + b * nn : b * nn;
                    h = coef >> 16;
                    if (j == k) begin
                        term[j] = (e * h) >> 31;
                        tneg[j] = 0;
                    end else begin
                        term[t] = (e * h) >> 31;
                        tneg[t] = (neg[j] != neg[k]) && nn != 0 && term[t] != 0;
                        t++;
                    end
                end
            end
            w.tag = c.tag;
            w.pxx = 32'(term[0]);
            w.pyy = 32'(term[1]);
            w.pzz = 32'(term[2]);
            w.pxy = with_sign(tneg[3], term[3]);
            w.pxz = with_sign(tneg[4], term[4]);
            w.pyz = with_sign(tneg[5], term[5]);
            w.nfx = with_sign(neg[0] && newf[0] != 0, newf[0]);
            w.nfy = with_sign(neg[1] && newf[1] != 0, newf[1]);
            w.nfz = with_sign(neg[2] && newf[2] != 0, newf[2]);
            w.fq = 17'(fq);
            w.clamp = clamp;
            want_q.push_back(w);
        endfunction

        function void cmp(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %h, actual %h", name, want, got);
                errors++;
            end
        endfunction

        function void check_tensor(t_tensor g);
            t_tensor w;
            if (want_q.size() == 0) begin
                $error("result beat with tag %h arrived with nothing expected", g.tag);
                errors++;
                return;
            end
            w = want_q.pop_front();
            cmp("tag_out", w.tag, g.tag);
            cmp("press_xx", w.pxx, g.pxx);
            cmp("press_yy", w.pyy, g.pyy);
            cmp("press_zz", w.pzz, g.pzz);
            cmp("press_xy", w.pxy, g.pxy);
            cmp("press_xz", w.pxz, g.pxz);
            cmp("press_yz", w.pyz, g.pyz);
            cmp("new_flux_x", w.nfx, g.nfx);
            cmp("new_flux_y", w.nfy, g.nfy);
            cmp("new_flux_z", w.nfz, g.nfz);
            cmp("reduced_flux", 32'(w.fq), 32'(g.fq));
            cmp("was_clamped", 32'(w.clamp), 32'(g.clamp));
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_wr_en = 0;
    logic [31:0] i_cfg_wr_data = 0;
    logic        i_valid = 0;
    logic        o_stall;
    logic [31:0] i_cell_tag = 0;
    logic [31:0] i_flux_x = 0, i_flux_y = 0, i_flux_z = 0;
    logic [31:0] i_photon_density = 0;
    logic        o_valid;
    logic        i_stall = 0;
    logic [31:0] o_tag_out, o_press_xx, o_press_yy, o_press_zz;
    logic [31:0] o_press_xy, o_press_xz, o_press_yz;
    logic [31:0] o_new_flux_x, o_new_flux_y, o_new_flux_z;
    logic [16:0] o_reduced_flux;
    logic        o_was_clamped;

    m1_eddington_tensor_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_wr_data(i_cfg_wr_data),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_cell_tag(i_cell_tag), .i_flux_x(i_flux_x), .i_flux_y(i_flux_y),
        .i_flux_z(i_flux_z), .i_photon_density(i_photon_density),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_tag_out(o_tag_out), .o_press_xx(o_press_xx), .o_press_yy(o_press_yy),
        .o_press_zz(o_press_zz), .o_press_xy(o_press_xy), .o_press_xz(o_press_xz),
        .o_press_yz(o_press_yz), .o_new_flux_x(o_new_flux_x),
        .o_new_flux_y(o_new_flux_y), .o_new_flux_z(o_new_flux_z),
        .o_reduced_flux(o_reduced_flux), .o_was_clamped(o_was_clamped)
    );

    t_tensor_board board = new();
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_request = 0;
    int  hold_left = 0;
    int  quiet_cycles = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Receiver side: random stall, or a long hold-off when asked for.
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_request = 0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_tensor g;
        if (i_rst_n && o_valid && !i_stall) begin
            g.tag = o_tag_out;
            g.pxx = o_press_xx; g.pyy = o_press_yy; g.pzz = o_press_zz;
            g.pxy = o_press_xy; g.pxz = o_press_xz; g.pyz = o_press_yz;
            g.nfx = o_new_flux_x; g.nfy = o_new_flux_y; g.nfz = o_new_flux_z;
            g.fq = o_reduced_flux;
            g.clamp = o_was_clamped;
            board.check_tensor(g);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= DOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_cell(t_cell c);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 0;
            @(posedge i_clk);
            @(negedge i_clk);
        end
        i_valid <= 1;
        i_cell_tag <= c.tag;
        i_flux_x <= c.fx;
        i_flux_y <= c.fy;
        i_flux_z <= c.fz;
        i_photon_density <= c.dens;
        do @(posedge i_clk); while (o_stall);
        board.note_cell(c);
    endtask

    // Stops offering beats and lets every expected result come out.
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 0;
        while (board.want_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic set_light(logic [31:0] c);
        @(negedge i_clk);
        i_cfg_wr_en <= 1;
        i_cfg_wr_data <= c;
        @(negedge i_clk);
        i_cfg_wr_en <= 0;
        board.light = 64'(c);
    endtask

    function automatic t_cell mk(logic [31:0] tag, logic [31:0] x, logic [31:0] y,
                                 logic [31:0] z, logic [31:0] e);
        t_cell c;
        c.tag = tag; c.fx = x; c.fy = y; c.fz = z; c.dens = e;
        return c;
    endfunction

    function automatic t_cell rand_cell();
        t_cell     c;
        bit [63:0] tgt;
        int        kind;
        c = mk($urandom, $urandom, $urandom, $urandom, $urandom);
        kind = $urandom_range(9);
        case (kind)
            0, 1, 2: ;
            3: begin
                // Small values, mostly below the clamp.
                c.fx = $urandom_range(4000) - 2000;
                c.fy = $urandom_range(4000) - 2000;
                c.fz = $urandom_range(4000) - 2000;
                c.dens = $urandom_range(100000);
            end
            4: begin
                c.fx = 0; c.fy = 0; c.fz = 0;
            end
            5: c.dens = 0;
            6, 7: begin
                // Flux along one axis with |F| near c*E, so f lands close to one.
                c.dens = $urandom_range(1 << 20);
                tgt = (board.light * 64'(c.dens)) >> 16;
                if (tgt > 64'h7FFF_FFF0) tgt = 64'h7FFF_FFF0;
                tgt = tgt + $urandom_range(4) - 2;
                c.fx = $urandom_range(1) ? 32'(tgt) : 32'(-tgt);
                c.fy = $urandom_range(3);
                c.fz = 0;
            end
            default: begin
                c.fx = $urandom_range(1 << 16) - (1 << 15);
                c.fy = $urandom_range(1 << 16) - (1 << 15);
                c.fz = $urandom_range(1 << 16) - (1 << 15);
            end
        endcase
        return c;
    endfunction

    initial begin
        logic [31:0] speeds[6];
        speeds = '{32'd65536, 32'd1, 32'hFFFF_FFFF, $urandom, 32'd0, 32'd3 << 16};
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        for (int p = 0; p < 6; p++) begin
            send_idle_pct = (p % 3 == 0) ? 14 : (p % 3 == 1) ? 52 : 0;
            recv_idle_pct = (p % 3 == 0) ? 52 : (p % 3 == 1) ? 14 : 0;
            set_light(speeds[p]);
            if (p == 0) begin
                send_cell(mk(0, 0, 0, 0, 0));
                send_cell(mk(32'hFFFF_FFFF, 0, 0, 0, 32'hFFFF_FFFF));
                send_cell(mk(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0));
                send_cell(mk(2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                             32'hFFFF_FFFF));
                send_cell(mk(3, 5, 0, 0, 5));
                send_cell(mk(4, 0, -5, 0, 5));
                send_cell(mk(5, 0, 0, 6, 5));
                send_cell(mk(6, 4, 0, 0, 5));
                send_cell(mk(7, 3, 4, 0, 5));
                send_cell(mk(8, -3, 4, -12, 13));
                send_cell(mk(9, 1, 0, 0, 0));
                send_cell(mk(10, -1, -1, -1, 1000));
                send_cell(mk(11, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1));
                send_cell(mk(12, 1000, -2000, 3000, 32'hFFFF_FFFF));
                send_cell(mk(13, 0, 0, 32'h8000_0000, 32'h8000_0000));
                send_cell(mk(14, 12345, 54321, -777, 70000));
                send_cell(mk(15, 0, 0, 0, 32'h5555_5555));
                send_cell(mk(16, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0F0F_0F0F,
                             32'hAAAA_AAAA));
            end
            for (int i = 0; i < 125; i++) begin
                // Long hold-off on the receiver while beats keep coming in.
                if (p == 1 && i == 20) hold_request = 1;
                send_cell(rand_cell());
            end
            drain();
        end

        if (board.errors == 0 && board.want_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
